[src/sipf_pkg.sv]
// ----------------------------------------------------------------------------
// sipf_pkg
// Shared types and constants of the scan isolated point filter.
// ----------------------------------------------------------------------------
package sipf_pkg;

    // field widths
    localparam int DIST_W  = 16;
    localparam int ANG_W   = 16;
    localparam int INT_W   = 8;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 16;
    localparam int CADDR_W = 2;

    // configuration register indexes
    localparam logic [CADDR_W-1:0] CFG_QUIET_INTENSITY = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_NEAR_DISTANCE   = 2'd1;
    localparam logic [CADDR_W-1:0] CFG_NEIGHBOR_DIST   = 2'd2;

    // register reset values
    localparam logic [INT_W-1:0]  QUIET_RESET    = 8'd0;
    localparam logic [DIST_W-1:0] NEAR_RESET     = 16'd200;
    localparam logic [DIST_W-1:0] NEIGHBOR_RESET = 16'd1000;

    // one range point
    typedef struct packed {
        logic [INT_W-1:0]  intensity;
        logic [ANG_W-1:0]  angle;
        logic [DIST_W-1:0] distance;
    } t_point;

    // one filtered result
    typedef struct packed {
        logic              scan_end;
        logic [INT_W-1:0]  intensity;
        logic [ANG_W-1:0]  angle;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  index;
    } t_result;

    // filter limits
    typedef struct packed {
        logic [INT_W-1:0]  quiet;
        logic [DIST_W-1:0] near;
        logic [DIST_W-1:0] neighbor;
    } t_cfg;

    // scan progress
    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_MANY
    } t_phase;

endpackage

[src/sipf_judge.sv]
// ----------------------------------------------------------------------------
// sipf_judge
// Decides whether one point is an isolated return, from its two neighbors.
// ----------------------------------------------------------------------------
module sipf_judge (
    input  sipf_pkg::t_point               i_cur,
    input  sipf_pkg::t_point               i_prev,
    input  sipf_pkg::t_point               i_next,
    input  sipf_pkg::t_cfg                 i_cfg,
    output logic [sipf_pkg::INT_W-1:0]     o_intensity
);

    logic                          cur_live;
    logic                          prev_live;
    logic                          next_live;
    logic [sipf_pkg::DIST_W-1:0]   prev_gap;
    logic [sipf_pkg::DIST_W-1:0]   next_gap;
    logic                          prev_ok;
    logic                          next_ok;

    // quiet tests
    assign cur_live  = i_cur.intensity  > i_cfg.quiet;
    assign prev_live = i_prev.intensity > i_cfg.quiet;
    assign next_live = i_next.intensity > i_cfg.quiet;

    // absolute distance gaps to the neighbors
    assign prev_gap = (i_prev.distance > i_cur.distance)
                    ? (i_prev.distance - i_cur.distance)
                    : (i_cur.distance - i_prev.distance);
    assign next_gap = (i_next.distance > i_cur.distance)
                    ? (i_next.distance - i_cur.distance)
                    : (i_cur.distance - i_next.distance);

    assign prev_ok = prev_live && (prev_gap < i_cfg.neighbor);
    assign next_ok = next_live && (next_gap < i_cfg.neighbor);

    // quiet points pass, too-near or unconfirmed live points are zeroed
    always_comb begin
        if (!cur_live) begin
            o_intensity = i_cur.intensity;
        end else if (i_cur.distance < i_cfg.near) begin
            o_intensity = '0;
        end else if (prev_ok || next_ok) begin
            o_intensity = i_cur.intensity;
        end else begin
            o_intensity = '0;
        end
    end

endmodule

[src/sipf_track.sv]
// ----------------------------------------------------------------------------
// sipf_track
// Keeps the scan history and forms up to three judged results per point.
// ----------------------------------------------------------------------------
module sipf_track #(
    parameter int MAX_SCAN_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  sipf_pkg::t_point     i_point,
    input  logic                 i_last,
    input  sipf_pkg::t_cfg       i_cfg,
    output logic [1:0]           o_push_n,
    output sipf_pkg::t_result    o_res [3]
);

    localparam int CW = (MAX_SCAN_POINTS > 1) ? $clog2(MAX_SCAN_POINTS) : 1;
    localparam logic [CW-1:0] SEEN_MAX = CW'(MAX_SCAN_POINTS - 1);

    sipf_pkg::t_phase  r_phase, n_phase;
    sipf_pkg::t_point  r_first, r_second, r_prev, r_pend;
    logic [CW-1:0]     r_seen, n_seen;
    logic [CW-1:0]     r_pend_idx;

    logic [CW+sipf_pkg::IDX_W-1:0] cur_ext;
    logic [CW+sipf_pkg::IDX_W-1:0] pend_ext;
    logic [sipf_pkg::IDX_W-1:0]    cur_idx;
    logic [sipf_pkg::IDX_W-1:0]    pend_idx;

    sipf_pkg::t_point  a_cur, a_prev, a_next;
    sipf_pkg::t_point  b_cur, b_prev, b_next;
    logic [sipf_pkg::INT_W-1:0] a_int, b_int, c_int;

    // point index as it leaves the block
    assign cur_ext  = {{sipf_pkg::IDX_W{1'b0}}, r_seen};
    assign pend_ext = {{sipf_pkg::IDX_W{1'b0}}, r_pend_idx};
    assign cur_idx  = cur_ext[sipf_pkg::IDX_W-1:0];
    assign pend_idx = pend_ext[sipf_pkg::IDX_W-1:0];

    // next scan phase and point counter
    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        if (i_accept) begin
            if (i_last) begin
                n_phase = sipf_pkg::PH_EMPTY;
                n_seen  = '0;
            end else begin
                if (r_seen < SEEN_MAX) begin
                    n_seen = r_seen + 1'b1;
                end
                case (r_phase)
                    sipf_pkg::PH_EMPTY: n_phase = sipf_pkg::PH_ONE;
                    sipf_pkg::PH_ONE:   n_phase = sipf_pkg::PH_MANY;
                    sipf_pkg::PH_MANY:  n_phase = sipf_pkg::PH_MANY;
                    default:            n_phase = sipf_pkg::PH_EMPTY;
                endcase
            end
        end
    end

    // neighbor selection and result count per phase
    always_comb begin
        a_cur    = i_point;
        a_prev   = i_point;
        a_next   = i_point;
        b_cur    = r_first;
        b_prev   = i_point;
        b_next   = i_point;
        o_push_n = 2'd0;
        o_res[0].index    = '0;
        o_res[0].scan_end = 1'b1;
        o_res[1].index    = '0;
        o_res[1].scan_end = 1'b1;
        case (r_phase)
            sipf_pkg::PH_EMPTY: begin
                o_push_n = i_last ? 2'd1 : 2'd0;
            end
            sipf_pkg::PH_ONE: begin
                a_prev   = r_first;
                a_next   = r_first;
                o_res[0].index    = cur_idx;
                o_res[0].scan_end = 1'b0;
                o_push_n = i_last ? 2'd2 : 2'd0;
            end
            sipf_pkg::PH_MANY: begin
                a_cur    = r_pend;
                a_prev   = r_prev;
                a_next   = i_point;
                b_cur    = i_point;
                b_prev   = r_pend;
                b_next   = r_first;
                o_res[0].index    = pend_idx;
                o_res[0].scan_end = 1'b0;
                o_res[1].index    = cur_idx;
                o_res[1].scan_end = 1'b0;
                o_push_n = i_last ? 2'd3 : 2'd1;
            end
            default: begin
                o_push_n = 2'd0;
            end
        endcase
        o_res[0].distance  = a_cur.distance;
        o_res[0].angle     = a_cur.angle;
        o_res[0].intensity = a_int;
        o_res[1].distance  = b_cur.distance;
        o_res[1].angle     = b_cur.angle;
        o_res[1].intensity = b_int;
        o_res[2].index     = '0;
        o_res[2].scan_end  = 1'b1;
        o_res[2].distance  = r_first.distance;
        o_res[2].angle     = r_first.angle;
        o_res[2].intensity = c_int;
    end

    // the three judges
    sipf_judge u_judge_a (
        .i_cur       (a_cur),
        .i_prev      (a_prev),
        .i_next      (a_next),
        .i_cfg       (i_cfg),
        .o_intensity (a_int)
    );

    sipf_judge u_judge_b (
        .i_cur       (b_cur),
        .i_prev      (b_prev),
        .i_next      (b_next),
        .i_cfg       (i_cfg),
        .o_intensity (b_int)
    );

    sipf_judge u_judge_c (
        .i_cur       (r_first),
        .i_prev      (i_point),
        .i_next      (r_second),
        .i_cfg       (i_cfg),
        .o_intensity (c_int)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sipf_pkg::PH_EMPTY;
            r_seen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
        end
    end

    // point history
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            case (r_phase)
                sipf_pkg::PH_EMPTY: begin
                    r_first <= i_point;
                end
                sipf_pkg::PH_ONE: begin
                    r_second   <= i_point;
                    r_prev     <= r_first;
                    r_pend     <= i_point;
                    r_pend_idx <= r_seen;
                end
                sipf_pkg::PH_MANY: begin
                    r_prev     <= r_pend;
                    r_pend     <= i_point;
                    r_pend_idx <= r_seen;
                end
                default: begin
                    r_first <= i_point;
                end
            endcase
        end
    end

endmodule

[src/sipf_out_queue.sv]
// ----------------------------------------------------------------------------
// sipf_out_queue
// Four-entry result queue that takes up to three results per cycle.
// ----------------------------------------------------------------------------
module sipf_out_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_n,
    input  sipf_pkg::t_result    i_res [3],
    input  logic                 i_pop_ready,
    output logic                 o_valid,
    output sipf_pkg::t_result    o_head,
    output logic                 o_room
);

    localparam int QD = 4;

    sipf_pkg::t_result r_q [QD];
    sipf_pkg::t_result n_q [QD];
    sipf_pkg::t_result sh  [QD];
    logic [2:0]        r_cnt, n_cnt;
    logic              pop;
    logic [2:0]        base;

    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_q[0];
    // room for a worst-case push of three
    assign o_room  = (r_cnt <= 3'd1);
    assign pop     = o_valid && i_pop_ready;
    assign base    = r_cnt - {2'b00, pop};
    assign n_cnt   = base + {1'b0, i_push_n};

    // shift the queue by the popped entry
    always_comb begin
        for (int i = 0; i < QD - 1; i++) begin
            sh[i] = pop ? r_q[i + 1] : r_q[i];
        end
        sh[QD-1] = r_q[QD-1];
    end

    // append new results behind the remaining ones
    always_comb begin
        for (int i = 0; i < QD; i++) begin
            logic [2:0] k;
            k = 3'(i) - base;
            n_q[i] = sh[i];
            if (3'(i) >= base && k < {1'b0, i_push_n}) begin
                n_q[i] = i_res[k[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

[src/scan_isolated_point_filter_unit.sv]
// ----------------------------------------------------------------------------
// scan_isolated_point_filter_unit
// Zeroes the intensity of isolated returns in a rotating range scan.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                        | tlast
//  s_axis    | in  | distance_mm 16, angle_centideg 16,         | scan_last
//            |     | intensity 8                                |
//  m_axis    | out | point_index 10, out_distance_mm 16,        | scan_end
//            |     | out_angle_centideg 16, out_intensity 8, 0s |
//  cfg       | in  | 0 quiet limit, 1 near limit, 2 neighbor limit
//
//  one point per cycle while s_axis_tready is high; a point is judged and queued
//  in the cycle its next neighbor is taken (the first and last points of a scan
//  in the cycle the scan ends), and its result leaves from the queue head; the point
//  ending a scan of three or more gives three results, which the queue drains;
//  s_axis_tready drops while more than one result is held in the four-entry queue
//  synchronous active-low reset drops any partial scan and queued results
// ----------------------------------------------------------------------------
module scan_isolated_point_filter_unit #(
    parameter int MAX_SCAN_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input points
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // distance_mm, angle_centideg, intensity
    input  logic                          s_axis_tlast,  // scan_last
    // filtered points
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [55:0]                   m_axis_tdata,  // point_index, out_distance_mm,
                                                         // out_angle_centideg, out_intensity
    output logic                          m_axis_tlast,  // scan_end
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [sipf_pkg::CADDR_W-1:0]  i_cfg_addr,
    input  logic [sipf_pkg::CFG_W-1:0]    i_cfg_data
);

    sipf_pkg::t_cfg     r_cfg;
    sipf_pkg::t_point   in_point;
    sipf_pkg::t_result  res [3];
    sipf_pkg::t_result  head;
    logic [1:0]         push_n;
    logic               accept;
    logic               room;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    assign in_point.distance  = s_axis_tdata[15:0];
    assign in_point.angle     = s_axis_tdata[31:16];
    assign in_point.intensity = s_axis_tdata[39:32];

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet    <= sipf_pkg::QUIET_RESET;
            r_cfg.near     <= sipf_pkg::NEAR_RESET;
            r_cfg.neighbor <= sipf_pkg::NEIGHBOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sipf_pkg::CFG_QUIET_INTENSITY: r_cfg.quiet    <= i_cfg_data[7:0];
                sipf_pkg::CFG_NEAR_DISTANCE:   r_cfg.near     <= i_cfg_data;
                sipf_pkg::CFG_NEIGHBOR_DIST:   r_cfg.neighbor <= i_cfg_data;
                default:                       r_cfg          <= r_cfg;
            endcase
        end
    end

    sipf_track #(
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_point  (in_point),
        .i_last   (s_axis_tlast),
        .i_cfg    (r_cfg),
        .o_push_n (push_n),
        .o_res    (res)
    );

    sipf_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (accept ? push_n : 2'd0),
        .i_res       (res),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_head      (head),
        .o_room      (room)
    );

    // result packing
    assign m_axis_tdata = {6'd0, head.intensity, head.angle, head.distance, head.index};
    assign m_axis_tlast = head.scan_end;

endmodule

[src/sipf_checker.sv]
// ----------------------------------------------------------------------------
// sipf_checker
// Port-level checks of the scan isolated point filter.
// ----------------------------------------------------------------------------
module sipf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the scan-end result is always point zero
    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[9:0] == 10'd0)
        else $error("scan end on nonzero index");

    // closing a scan always leaves a result to send
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after scan end");

endmodule

bind scan_isolated_point_filter_unit sipf_checker u_sipf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
